### sv/pgac_pkg.sv
// Shared types and constants of the pixel to gray and alpha converter.
package pgac_pkg;

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_PRES  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_ALPHA = 2'd2;

    // Pixel format codes.
    localparam logic [2:0] FMT_GRAY            = 3'd0;
    localparam logic [2:0] FMT_TRUECOLOR       = 3'd1;
    localparam logic [2:0] FMT_INDEXED         = 3'd2;
    localparam logic [2:0] FMT_GRAY_ALPHA      = 3'd3;
    localparam logic [2:0] FMT_TRUECOLOR_ALPHA = 3'd4;

    // Item kinds carried in tuser.
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_PIXEL     = 1'b1;

    // Luma weights and fixed levels.
    localparam logic [7:0] LUMA_R       = 8'd77;
    localparam logic [7:0] LUMA_G       = 8'd150;
    localparam logic [7:0] LUMA_B       = 8'd29;
    localparam logic [7:0] GRAY_UNKNOWN = 8'd128;
    localparam logic [7:0] LEVEL_FULL   = 8'd255;

    // Per-item control that travels with the pixel down the pipeline.
    typedef struct packed {
        logic       use_luma;
        logic [7:0] bypass_gray;
        logic       blend;
        logic [7:0] alpha;
        logic       last;
    } pgac_tag_t;

endpackage

### sv/pgac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/pgac_luma.sv
// Two-stage luma unit: weighted products, then sum and gray selection.
module pgac_luma (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    input  pgac_pkg::pgac_tag_t  in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_gray,
    output pgac_pkg::pgac_tag_t  out_tag
);
    import pgac_pkg::*;

    logic        va_reg, va_next;
    logic        vb_reg, vb_next;
    logic        en_a, en_b;
    logic [15:0] pr_w, pg_w, pb_w;
    logic [14:0] pr_reg;
    logic [15:0] pg_reg;
    logic [12:0] pb_reg;
    pgac_tag_t   tag_a_reg, tag_b_reg;
    logic [15:0] sum_w;
    logic [7:0]  gray_reg;

    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    assign va_next = en_a ? in_valid : va_reg;
    assign vb_next = en_b ? va_reg : vb_reg;

    assign pr_w  = 16'(red) * 16'(LUMA_R);
    assign pg_w  = 16'(green) * 16'(LUMA_G);
    assign pb_w  = 16'(blue) * 16'(LUMA_B);
    assign sum_w = 16'(pr_reg) + pg_reg + 16'(pb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            pr_reg    <= pr_w[14:0];
            pg_reg    <= pg_w;
            pb_reg    <= pb_w[12:0];
            tag_a_reg <= in_tag;
        end
        if (en_b)
        begin
            gray_reg  <= tag_a_reg.use_luma ? sum_w[15:8] : tag_a_reg.bypass_gray;
            tag_b_reg <= tag_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_gray  = gray_reg;
    assign out_tag   = tag_b_reg;

endmodule

### sv/pgac_blend.sv
// Two-stage blend over white when the tag asks for it: weighted sum, then exact division by 255.
module pgac_blend (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_gray,
    input  pgac_pkg::pgac_tag_t  in_tag,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_gray,
    output logic [7:0]           out_alpha,
    output logic                 out_last
);
    import pgac_pkg::*;

    logic        va_reg, va_next;
    logic        vb_reg, vb_next;
    logic        en_a, en_b;
    logic [7:0]  inv_w;
    logic [15:0] ga_w, wa_w, x_w;
    logic [15:0] x_reg;
    logic [7:0]  g_a_reg, alpha_a_reg;
    logic        blend_a_reg, last_a_reg;
    logic [16:0] t_w;
    logic [7:0]  gray_reg, alpha_reg;
    logic        last_reg;

    assign en_b     = !vb_reg || out_ready;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    assign va_next = en_a ? in_valid : va_reg;
    assign vb_next = en_b ? va_reg : vb_reg;

    // The sum g*a + 255*(255-a) never exceeds 255*255, so 16 bits hold it.
    assign inv_w = LEVEL_FULL - in_tag.alpha;
    assign ga_w  = 16'(in_gray) * 16'(in_tag.alpha);
    assign wa_w  = {inv_w, 8'h00} - 16'(inv_w);
    assign x_w   = ga_w + wa_w;

    // floor(x / 255) for any x up to 255*255 is (x + (x >> 8) + 1) >> 8.
    assign t_w = 17'(x_reg) + 17'(x_reg[15:8]) + 17'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            x_reg       <= x_w;
            g_a_reg     <= in_gray;
            alpha_a_reg <= in_tag.alpha;
            blend_a_reg <= in_tag.blend;
            last_a_reg  <= in_tag.last;
        end
        if (en_b)
        begin
            gray_reg  <= blend_a_reg ? t_w[15:8] : g_a_reg;
            alpha_reg <= alpha_a_reg;
            last_reg  <= last_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_gray  = gray_reg;
    assign out_alpha = alpha_reg;
    assign out_last  = last_reg;

endmodule

### sv/pixel_to_gray_alpha_converter.sv
// Top level of the pixel to gray and alpha converter.
// A pixel result passes the input stage, then the luma stages, then the blend stages.
// Throughput: one item per clock unless the output stalls; a palette write uses one input slot, no result.
// Each stage holds its item on a stall, and a bubble ahead of a stall is filled.
// Reset clears the configuration registers and every stage valid bit.
// Palette contents stay undefined after reset until written.
module pixel_to_gray_alpha_converter #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pgac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pgac_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // palette_index, pal_red, pal_green, pal_blue, pal_alpha,
    // sample_a, sample_b, sample_c, sample_d (8 bits each, lowest first)
    input  logic [pgac_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    // func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gray_value, alpha_value (lowest first)
    output logic [pgac_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import pgac_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);

    logic [2:0]  pixel_format_reg;
    logic        palette_present_reg;
    logic        palette_alpha_reg;

    logic        accept;
    logic        pal_we;
    logic [7:0]  in_index, in_sa;
    logic [31:0] pal_wdata;
    logic [31:0] pal_rdata;
    logic [31:0] entry;

    logic        v1_reg, v1_next;
    logic        en1;
    logic [7:0]  sa_reg, sb_reg, sc_reg, sd_reg;
    logic        last_reg;
    logic        in_range_reg;

    logic [7:0]  sel_r, sel_g, sel_b;
    pgac_tag_t   tag1;

    logic        luma_ready, luma_valid;
    logic [7:0]  luma_gray;
    pgac_tag_t   luma_tag;
    logic        blend_ready;
    logic [7:0]  out_gray, out_alpha;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg    <= FMT_GRAY;
            palette_present_reg <= 1'b0;
            palette_alpha_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:  pixel_format_reg    <= cfg_data;
                CFG_PALETTE_PRES:  palette_present_reg <= cfg_data[0];
                CFG_PALETTE_ALPHA: palette_alpha_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en1      = !v1_reg || luma_ready;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    assign in_index  = s_tdata[7:0];
    assign in_sa     = s_tdata[47:40];
    assign pal_wdata = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
    assign pal_we    = accept && (s_tuser == FUNC_PAL_WRITE) && ({1'b0, in_index} < ENTRIES);

    // The palette is written as the item is accepted, so a pixel right behind reads it.
    pgac_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (in_index[AW-1:0]),
        .wdata (pal_wdata),
        .re    (en1),
        .raddr (in_sa[AW-1:0]),
        .rdata (pal_rdata)
    );

    assign v1_next = en1 ? (s_tvalid && (s_tuser == FUNC_PIXEL)) : v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sa_reg       <= in_sa;
            sb_reg       <= s_tdata[55:48];
            sc_reg       <= s_tdata[63:56];
            sd_reg       <= s_tdata[71:64];
            last_reg     <= s_tlast;
            in_range_reg <= ({1'b0, in_sa} < ENTRIES);
        end
    end

    // An index beyond the palette reads as an all-zero entry.
    assign entry = in_range_reg ? pal_rdata : 32'd0;

    always_comb
    begin
        sel_r            = sa_reg;
        sel_g            = sb_reg;
        sel_b            = sc_reg;
        tag1.use_luma    = 1'b0;
        tag1.bypass_gray = sa_reg;
        tag1.blend       = 1'b0;
        tag1.alpha       = LEVEL_FULL;
        tag1.last        = last_reg;
        case (pixel_format_reg)
            FMT_GRAY: ;
            FMT_TRUECOLOR:
            begin
                tag1.use_luma = 1'b1;
            end
            FMT_INDEXED:
            begin
                if (palette_present_reg)
                begin
                    sel_r         = entry[31:24];
                    sel_g         = entry[23:16];
                    sel_b         = entry[15:8];
                    tag1.use_luma = 1'b1;
                    if (palette_alpha_reg)
                    begin
                        tag1.alpha = entry[7:0];
                    end
                end
            end
            FMT_GRAY_ALPHA:
            begin
                tag1.blend = 1'b1;
                tag1.alpha = sb_reg;
            end
            FMT_TRUECOLOR_ALPHA:
            begin
                tag1.use_luma = 1'b1;
                tag1.blend    = 1'b1;
                tag1.alpha    = sd_reg;
            end
            default:
            begin
                tag1.bypass_gray = GRAY_UNKNOWN;
            end
        endcase
    end

    pgac_luma u_luma (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1_reg),
        .in_ready  (luma_ready),
        .red       (sel_r),
        .green     (sel_g),
        .blue      (sel_b),
        .in_tag    (tag1),
        .out_valid (luma_valid),
        .out_ready (blend_ready),
        .out_gray  (luma_gray),
        .out_tag   (luma_tag)
    );

    pgac_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (luma_valid),
        .in_ready  (blend_ready),
        .in_gray   (luma_gray),
        .in_tag    (luma_tag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_gray  (out_gray),
        .out_alpha (out_alpha),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_alpha, out_gray};

endmodule

### sv/pgac_checker.sv
// Port-level checks of the converter and the bind that attaches them.
module pgac_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pgac_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tlast
);
    import pgac_pkg::*;

    // A result that waits keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // The input side only blocks when a result waits at the output.
    a_ready_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input blocked without an output stall");

    // With the sink ready throughout, a pixel result is there to be taken once its item,
    // after acceptance, has passed the input stage, the luma stages and the blend stages.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == FUNC_PIXEL) && m_tready)
        ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("pixel result missing after pipeline latency");

endmodule

bind pixel_to_gray_alpha_converter pgac_checker u_pgac_checker (.*);
